// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define CRPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CRPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/crps_pkg.sv =====
// shared types and constants of the path sampler
package crps_pkg;

    localparam int IDX_W       = 6;
    localparam int COORD_W     = 32;
    localparam int LAP_W       = 16;
    localparam int CNT_W       = 7;
    localparam int HW          = 38;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_WR,
        OP_DIFF,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_LOAD_FIN,
        OP_SMP_START,
        OP_TOTAL,
        OP_DIV_STEP,
        OP_LAP,
        OP_SRCH,
        OP_FETCH,
        OP_COEF,
        OP_MUL,
        OP_ADD,
        OP_OUT,
        OP_OUT_ZERO
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic [1:0] stage;
    } t_cmd;

    typedef struct packed {
        logic ld_short;
        logic bad;
        logic total_zero;
        logic hit;
        logic miss;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/crps_ctrl.sv =====
// sequencer for point loads and path samples
module crps_ctrl import crps_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_kind,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LDIFF, ST_LSQ, ST_ROOT, ST_LFIN, ST_TOTAL, ST_LDIV, ST_LAP,
        ST_SRCH, ST_TDIV, ST_FETCH, ST_COEF, ST_HORN, ST_OUT, ST_ZERO
    } t_state;

    localparam logic [5:0] TDIV_LAST = 6'(FRAC_BITS - 1);

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_stage, n_stage;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt + 6'd1;
        n_axis      = r_axis;
        n_stage     = r_stage;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = 2'd0;
        o_cmd.stage = 2'd0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                n_cnt      = 6'd0;
                if (i_s_tvalid) begin
                    if (!i_kind) begin
                        o_cmd.op = OP_LOAD_WR;
                        if (!i_sts.ld_short) n_state = ST_LDIFF;
                    end else begin
                        o_cmd.op = OP_SMP_START;
                        n_state  = i_sts.bad ? ST_ZERO : ST_TOTAL;
                    end
                end
            end
            ST_LDIFF: begin
                o_cmd.op = OP_DIFF;
                n_cnt    = 6'd0;
                n_state  = ST_LSQ;
            end
            ST_LSQ: begin
                o_cmd.op  = r_cnt[0] ? OP_SQ_ACC : OP_SQ_MUL;
                o_cmd.sel = r_cnt[2:1];
                if (r_cnt == 6'd5) begin
                    n_cnt   = 6'd0;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.op = (r_cnt == 6'd0) ? OP_ROOT_INIT : OP_ROOT_STEP;
                if (r_cnt == 6'd32) n_state = ST_LFIN;
            end
            ST_LFIN: begin
                o_cmd.op = OP_LOAD_FIN;
                n_state  = ST_IDLE;
            end
            ST_TOTAL: begin
                o_cmd.op = OP_TOTAL;
                n_cnt    = 6'd0;
                n_state  = i_sts.total_zero ? ST_ZERO : ST_LDIV;
            end
            ST_LDIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == 6'd30) n_state = ST_LAP;
            end
            ST_LAP: begin
                o_cmd.op = OP_LAP;
                n_state  = ST_SRCH;
            end
            ST_SRCH: begin
                o_cmd.op = OP_SRCH;
                n_cnt    = 6'd0;
                if (i_sts.hit)       n_state = ST_TDIV;
                else if (i_sts.miss) n_state = ST_ZERO;
            end
            ST_TDIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == TDIV_LAST) begin
                    n_cnt   = 6'd0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.op  = OP_FETCH;
                o_cmd.sel = r_cnt[1:0];
                if (r_cnt == 6'd3) n_state = ST_COEF;
            end
            ST_COEF: begin
                o_cmd.op = OP_COEF;
                n_cnt    = 6'd0;
                n_axis   = 2'd0;
                n_stage  = 2'd0;
                n_state  = ST_HORN;
            end
            ST_HORN: begin
                o_cmd.op    = r_cnt[0] ? OP_ADD : OP_MUL;
                o_cmd.sel   = r_axis;
                o_cmd.stage = r_stage;
                if (r_cnt[0]) begin
                    if (r_axis == 2'd2) begin
                        n_axis  = 2'd0;
                        n_stage = r_stage + 2'd1;
                        if (r_stage == 2'd2) n_state = ST_OUT;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_OUT_ZERO;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 6'd0;
            r_axis  <= 2'd0;
            r_stage <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_stage <= n_stage;
        end
    end

endmodule

// ===== rtl/crps_dp.sv =====
// point stores, length table, arithmetic units and output register
module crps_dp import crps_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int MW = $clog2(MAX_POINTS + 1);
    localparam int CW = (MW > CNT_W) ? MW : CNT_W;
    localparam int PW = HW + FRAC_BITS + 1;
    localparam logic signed [HW-1:0] S_MAX = 38'sh007FFFFFFF;
    localparam logic signed [HW-1:0] S_MIN = -38'sh0080000000;

    logic [IDX_W-1:0]   in_idx;
    logic [COORD_W-1:0] in_c [3];
    logic [COORD_W-1:0] in_travel;

    assign in_idx    = i_s_tdata[5:0];
    assign in_c[0]   = i_s_tdata[37:6];
    assign in_c[1]   = i_s_tdata[69:38];
    assign in_c[2]   = i_s_tdata[101:70];
    assign in_travel = i_s_tdata[133:102];

    logic [COORD_W-1:0] mem_p [3][MAX_POINTS];
    logic [COORD_W-1:0] mem_c [MAX_POINTS];
    logic [COORD_W-1:0] r_rd_p [3];
    logic [COORD_W-1:0] r_rd_c;

    logic [CNT_W-1:0] r_count;
    logic [MW-1:0]    m;
    logic [CW-1:0]    count_ext;

    logic [AW-1:0]      r_idx;
    logic [COORD_W-1:0] r_new [3];
    logic [30:0]        r_mag [3];
    logic               r_big;
    logic [61:0]        r_sq;
    logic [63:0]        r_acc, r_n, r_root, r_bit;
    logic [COORD_W-1:0] r_cprev;

    logic [30:0] r_travel, r_rem, r_quo, r_dsr, r_len;
    logic [LAP_W-1:0] r_lap;
    logic [MW-1:0] r_k, r_j;
    logic [COORD_W-1:0] r_prev;

    logic [COORD_W-1:0] r_p [3][4];
    logic signed [HW-1:0] r_cb [3];
    logic signed [HW-1:0] r_ccf [3];
    logic signed [HW-1:0] r_cp1 [3];
    logic signed [HW-1:0] r_h [3];
    logic signed [PW-1:0] r_prod;

    logic               r_valid;
    logic [COORD_W-1:0] r_pos [3];
    logic [LAP_W-1:0]   r_lap_o;
    logic               r_ok;

    logic               in_range;
    logic [AW-1:0]      rd_addr;
    logic               c_we;
    logic [AW-1:0]      c_waddr;
    logic [COORD_W-1:0] c_wdata;
    logic [31:0]        seg_len;
    logic [32:0]        cum_sum;
    logic [31:0]        div_tmp;
    logic               div_ge;
    logic [63:0]        root_trial;
    logic [MW-1:0]      ip, j1, j2, j2s;
    logic               srch_in;
    logic [FRAC_BITS-1:0] t_val;

    assign count_ext = CW'(r_count);
    assign m = (count_ext > CW'(MAX_POINTS)) ? MW'(MAX_POINTS) : MW'(count_ext);
    assign in_range = CW'(in_idx) < CW'(MAX_POINTS);
    assign t_val = r_quo[FRAC_BITS-1:0];

    assign ip  = (r_j == '0) ? m - MW'(1) : r_j - MW'(1);
    assign j1  = r_j + MW'(1);
    assign j2s = r_j + MW'(2);
    assign j2  = (j2s == m) ? '0 : j2s;

    assign srch_in = ({1'b0, r_len} >= r_prev) && ({1'b0, r_len} < r_rd_c);

    always_comb begin
        case (i_cmd.op)
            OP_LOAD_WR:   rd_addr = AW'(AW'(in_idx) - AW'(1));
            OP_SMP_START: rd_addr = AW'(m - MW'(1));
            OP_SRCH:      rd_addr = AW'(r_k + MW'(1));
            OP_FETCH: begin
                case (i_cmd.sel)
                    2'd0:    rd_addr = AW'(ip);
                    2'd1:    rd_addr = AW'(r_j);
                    2'd2:    rd_addr = AW'(j1);
                    default: rd_addr = AW'(j2);
                endcase
            end
            default:      rd_addr = '0;
        endcase
    end

    assign seg_len = (r_big || (r_root[63:31] != '0)) ? 32'h7FFFFFFF
                                                       : {1'b0, r_root[30:0]};
    assign cum_sum = {1'b0, r_cprev} + {1'b0, seg_len};

    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_idx;
        c_wdata = '0;
        if (i_cmd.op == OP_LOAD_WR && in_idx == '0) begin
            c_we    = 1'b1;
            c_waddr = '0;
        end else if (i_cmd.op == OP_LOAD_FIN) begin
            c_we    = 1'b1;
            c_wdata = (cum_sum > 33'h07FFFFFFF) ? 32'h7FFFFFFF : cum_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_WR && in_range) begin
            for (int a = 0; a < 3; a++) mem_p[a][AW'(in_idx)] <= in_c[a];
        end
        if (c_we) mem_c[c_waddr] <= c_wdata;
        for (int a = 0; a < 3; a++) r_rd_p[a] <= mem_p[a][rd_addr];
        r_rd_c <= mem_c[rd_addr];
    end

    assign div_tmp    = {r_rem, r_quo[30]};
    assign div_ge     = div_tmp >= {1'b0, r_dsr};
    assign root_trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_WR: begin
                r_idx <= AW'(in_idx);
                for (int a = 0; a < 3; a++) r_new[a] <= in_c[a];
            end
            OP_DIFF: begin
                logic signed [32:0] d;
                logic [32:0] mg;
                logic big;
                big = 1'b0;
                for (int a = 0; a < 3; a++) begin
                    d  = $signed({r_new[a][31], r_new[a]}) -
                         $signed({r_rd_p[a][31], r_rd_p[a]});
                    mg = d[32] ? 33'(-d) : 33'(d);
                    r_mag[a] <= mg[30:0];
                    if (mg[32:31] != 2'b00) big = 1'b1;
                end
                r_big   <= big;
                r_acc   <= '0;
                r_cprev <= r_rd_c;
            end
            OP_SQ_MUL: begin
                for (int a = 0; a < 3; a++)
                    if (i_cmd.sel == 2'(a)) r_sq <= r_mag[a] * r_mag[a];
            end
            OP_SQ_ACC: r_acc <= r_acc + {2'b00, r_sq};
            OP_ROOT_INIT: begin
                r_n    <= r_acc;
                r_root <= '0;
                r_bit  <= 64'h4000000000000000;
            end
            OP_ROOT_STEP: begin
                if (r_n >= root_trial) begin
                    r_n    <= r_n - root_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_SMP_START: r_travel <= in_travel[30:0];
            OP_TOTAL: begin
                r_rem <= '0;
                r_quo <= r_travel;
                r_dsr <= r_rd_c[30:0];
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? 31'(div_tmp - {1'b0, r_dsr}) : div_tmp[30:0];
                r_quo <= {r_quo[29:0], div_ge};
            end
            OP_LAP: begin
                r_lap <= (r_quo[30:16] != '0) ? '1 : r_quo[15:0];
                r_len <= r_rem;
                r_k   <= '0;
            end
            OP_SRCH: begin
                if (r_k != '0 && srch_in) begin
                    r_j   <= r_k - MW'(1);
                    r_rem <= 31'({1'b0, r_len} - r_prev);
                    r_dsr <= 31'(r_rd_c - r_prev);
                    r_quo <= '0;
                end else begin
                    r_prev <= r_rd_c;
                    r_k    <= r_k + MW'(1);
                end
            end
            OP_FETCH: begin
                for (int s = 1; s < 4; s++)
                    if (i_cmd.sel == 2'(s))
                        for (int a = 0; a < 3; a++) r_p[a][s-1] <= r_rd_p[a];
            end
            OP_COEF: begin
                logic signed [HW-1:0] p0, p1, p2, p3;
                for (int a = 0; a < 3; a++) begin
                    p0 = HW'($signed(r_p[a][0]));
                    p1 = HW'($signed(r_p[a][1]));
                    p2 = HW'($signed(r_p[a][2]));
                    p3 = HW'($signed(r_rd_p[a]));
                    r_cb[a]  <= p2 - p0;
                    r_ccf[a] <= 2 * p0 - 5 * p1 + 4 * p2 - p3;
                    r_h[a]   <= -p0 + 3 * p1 - 3 * p2 + p3;
                    r_cp1[a] <= 2 * p1;
                end
            end
            OP_MUL: begin
                for (int a = 0; a < 3; a++)
                    if (i_cmd.sel == 2'(a))
                        r_prod <= PW'(r_h[a]) * $signed({1'b0, t_val});
            end
            OP_ADD: begin
                for (int a = 0; a < 3; a++)
                    if (i_cmd.sel == 2'(a)) begin
                        case (i_cmd.stage)
                            2'd0:    r_h[a] <= r_ccf[a] + HW'(r_prod >>> FRAC_BITS);
                            2'd1:    r_h[a] <= r_cb[a] + HW'(r_prod >>> FRAC_BITS);
                            default: r_h[a] <= r_cp1[a] + HW'(r_prod >>> FRAC_BITS);
                        endcase
                    end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            logic signed [HW-1:0] v;
            for (int a = 0; a < 3; a++) begin
                v = r_h[a] >>> 1;
                if (v > S_MAX)      r_pos[a] <= 32'h7FFFFFFF;
                else if (v < S_MIN) r_pos[a] <= 32'h80000000;
                else                r_pos[a] <= v[31:0];
            end
            r_lap_o <= r_lap;
        end else if (i_cmd.op == OP_OUT_ZERO) begin
            for (int a = 0; a < 3; a++) r_pos[a] <= '0;
            r_lap_o <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) r_count <= i_cfg_data;
            if (i_cmd.op == OP_OUT || i_cmd.op == OP_OUT_ZERO) begin
                r_valid <= 1'b1;
                r_ok    <= (i_cmd.op == OP_OUT);
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    assign o_sts.ld_short   = (in_idx == '0) || !in_range;
    assign o_sts.bad        = in_travel[31] || (m < MW'(2));
    assign o_sts.total_zero = (r_rd_c == '0);
    assign o_sts.hit        = (r_k != '0) && srch_in;
    assign o_sts.miss       = (r_k != '0) && !srch_in && (r_k == m - MW'(1));
    assign o_sts.out_busy   = r_valid && !i_m_tready;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_lap_o, r_pos[2], r_pos[1], r_pos[0]};
    assign o_m_tuser  = r_ok;

endmodule

// ===== rtl/catmull_rom_path_sampler_core.sv =====
// a point load at index 0 or out of range is finished on acceptance, else it runs diff,
// squares, a 32-step root and the length table write; a valid sample on segment j runs
// a 31-step lap divide, one length table read per segment searched, a FRAC_BITS-step t
// divide and the cubic on one shared multiplier; rejected samples (negative travel, short
// path, zero length, no segment) give an all-zero result with ok low
// one item at a time, input taken again while a result waits; sync active-low reset clears
// control and point_count, the stores are not cleared
`include "assert_macros.svh"

module catmull_rom_path_sampler_core import crps_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // point_index, coord_x, coord_y, coord_z, travel
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // kind
    input  logic                   i_s_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pos_x, pos_y, pos_z, lap
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // ok
    output logic                   o_m_tuser
);

    t_cmd cmd;
    t_sts sts;

    crps_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    crps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    `CRPS_ASSERT(a_accept_starts_op, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |-> (cmd.op == OP_LOAD_WR || cmd.op == OP_SMP_START), "transfer without a start command")
    `CRPS_ASSERT(a_no_result_overwrite, i_clk, i_rst_n, (cmd.op == OP_OUT || cmd.op == OP_OUT_ZERO) |-> !(o_m_tvalid && !i_m_tready), "result overwritten before transfer")
    `CRPS_ASSERT_ALWAYS(a_hit_miss_exclusive, i_clk, (cmd.op == OP_SRCH) |-> !(sts.hit && sts.miss), "search hit and miss together")

endmodule

// ===== test/catmull_rom_path_sampler_core_tb.sv =====
// self-checking testbench of the catmull-rom path sampler core: directed table then random traffic
module catmull_rom_path_sampler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crps_pkg::*;

    localparam int NPTS      = 64;
    localparam int FRAC      = 16;
    localparam int CYC_LIMIT = 3000000;
    localparam int HOLD_CYC  = 3000;
    localparam int TAIL_CYC  = 200;

    typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] lap;
        logic        ok;
    } t_sample;

    typedef struct {
        t_row_kind   kind;
        logic [5:0]  idx;
        logic [31:0] x, y, z, trav;
        logic [6:0]  cnt;
        bit          given;
        t_sample     res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    catmull_rom_path_sampler_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] px [NPTS];
    logic [31:0] py [NPTS];
    logic [31:0] pz [NPTS];
    logic [31:0] cum_len [NPTS];
    logic [6:0]  path_cnt;

    t_sample pending_samples[$];
    t_row    dir_rows[$];
    int      send_idle, recv_idle;
    int      n_errors;
    int      cycles;
    bit      hold_req, hold_done;
    int      hold_cnt;

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] seg_length(int a, int b);
        longint d[3];
        longint mag;
        logic [63:0] acc, r;
        d[0] = longint'($signed(px[b])) - longint'($signed(px[a]));
        d[1] = longint'($signed(py[b])) - longint'($signed(py[a]));
        d[2] = longint'($signed(pz[b])) - longint'($signed(pz[a]));
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            mag = d[k] < 0 ? -d[k] : d[k];
            if (mag >= 64'h8000_0000) return 32'h7FFF_FFFF;
            acc = acc + 64'(mag) * 64'(mag);
        end
        r = isqrt(acc);
        return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    function automatic logic [31:0] spline(logic [31:0] a0, logic [31:0] a1,
                                           logic [31:0] a2, logic [31:0] a3, longint t);
        longint p0, p1, p2, p3, cb, cc, cd, h;
        p0 = $signed(a0);
        p1 = $signed(a1);
        p2 = $signed(a2);
        p3 = $signed(a3);
        cb = p2 - p0;
        cc = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        cd = -p0 + 3 * p1 - 3 * p2 + p3;
        h = cd;
        h = cc + ((h * t) >>> FRAC);
        h = cb + ((h * t) >>> FRAC);
        h = 2 * p1 + ((h * t) >>> FRAC);
        h = h >>> 1;
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    // updates the point tables; returns 1 when a sample result is due
    function automatic bit predict_item(logic kind, logic [5:0] idx, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z, logic [31:0] trav,
                                        output t_sample r);
        int m, j, ip, i1, i2;
        bit found;
        logic [63:0] s, q, t, len;
        logic [31:0] total, seg;
        r = '0;
        if (kind == 1'b0) begin
            px[idx] = x;
            py[idx] = y;
            pz[idx] = z;
            if (idx == 0) begin
                cum_len[0] = 0;
            end else begin
                s = 64'(cum_len[idx-1]) + 64'(seg_length(idx - 1, idx));
                cum_len[idx] = s > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : s[31:0];
            end
            return 1'b0;
        end
        m = path_cnt > NPTS ? NPTS : path_cnt;
        if (trav[31] || m < 2) return 1'b1;
        total = cum_len[m-1];
        if (total == 0) return 1'b1;
        q = 64'(trav) / 64'(total);
        len = 64'(trav) % 64'(total);
        found = 0;
        j = 0;
        for (int i = 0; i + 1 < m; i++) begin
            if (!found && len >= cum_len[i] && len < cum_len[i+1]) begin
                j = i;
                found = 1;
            end
        end
        if (!found) return 1'b1;
        seg = cum_len[j+1] - cum_len[j];
        t = (64'(len[31:0] - cum_len[j]) << FRAC) / 64'(seg);
        ip = (j + m - 1) % m;
        i1 = (j + 1) % m;
        i2 = (j + 2) % m;
        r.pos_x = spline(px[ip], px[j], px[i1], px[i2], longint'(t));
        r.pos_y = spline(py[ip], py[j], py[i1], py[i2], longint'(t));
        r.pos_z = spline(pz[ip], pz[j], pz[i1], pz[i2], longint'(t));
        r.lap = q > 64'd65535 ? 16'hFFFF : q[15:0];
        r.ok = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_item(logic kind, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] trav, bit given, t_sample gres);
        t_sample r;
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, trav, z, y, x, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (predict_item(kind, idx, x, y, z, trav, r))
            pending_samples.insert(pending_samples.size(), given ? gres : r);
    endtask

    task automatic write_count(logic [6:0] cnt);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        path_cnt = cnt;
    endtask

    task automatic add_row(t_row_kind k, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] trav, logic [6:0] cnt, bit given);
        t_row w;
        w.kind  = k;
        w.idx   = idx;
        w.x     = x;
        w.y     = y;
        w.z     = z;
        w.trav  = trav;
        w.cnt   = cnt;
        w.given = given;
        w.res   = '0;
        dir_rows.insert(dir_rows.size(), w);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    function automatic logic [31:0] rand_travel();
        int m;
        logic [63:0] lim;
        m = path_cnt > NPTS ? NPTS : path_cnt;
        lim = (m >= 2) ? 64'(cum_len[m-1]) * 3 : 64'd100;
        if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
        if (lim == 0) lim = 1;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return (m >= 2) ? cum_len[$urandom_range(0, m - 1)] : 32'd0;
            default: return 32'($urandom) % lim[31:0];
        endcase
    endfunction

    task automatic load_path(int n);
        for (int i = 0; i < n; i++)
            send_item(1'b0, 6'(i), rand_coord(), rand_coord(), rand_coord(), 32'd0, 0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            hold_cnt   <= HOLD_CYC;
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_samples.size() == 0) begin
                $error("result with nothing pending: tdata %h tuser %b", o_m_tdata, o_m_tuser);
                n_errors++;
            end else begin
                e = pending_samples.pop_front();
                if (o_m_tdata[31:0] !== e.pos_x) begin
                    $error("pos_x expected %h actual %h", e.pos_x, o_m_tdata[31:0]);
                    n_errors++;
                end
                if (o_m_tdata[63:32] !== e.pos_y) begin
                    $error("pos_y expected %h actual %h", e.pos_y, o_m_tdata[63:32]);
                    n_errors++;
                end
                if (o_m_tdata[95:64] !== e.pos_z) begin
                    $error("pos_z expected %h actual %h", e.pos_z, o_m_tdata[95:64]);
                    n_errors++;
                end
                if (o_m_tdata[111:96] !== e.lap) begin
                    $error("lap expected %h actual %h", e.lap, o_m_tdata[111:96]);
                    n_errors++;
                end
                if (o_m_tuser !== e.ok) begin
                    $error("ok expected %b actual %b", e.ok, o_m_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n_items, n, cnt_sel;
        logic [6:0] cnts[9];
        cnts      = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd8, 7'd64, 7'd127, 7'd33};
        n_errors  = 0;
        cycles    = 0;
        hold_req  = 0;
        hold_done = 0;
        hold_cnt  = 0;
        send_idle = 0;
        recv_idle = 0;
        path_cnt  = 0;
        for (int i = 0; i < NPTS; i++) begin
            px[i] = 0;
            py[i] = 0;
            pz[i] = 0;
            cum_len[i] = 0;
        end
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; given rows carry a typed-in result of all zeros
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'd0, 0, 1);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 1);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h8000_0000, 0, 1);
        add_row(ROW_LOAD, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD, 1, 32'h0001_0000, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 7'd1, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h0001_0000, 0, 1);
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 7'd2, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'd0, 0, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h0000_8000, 0, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h8000_0000, 0, 1);
        add_row(ROW_LOAD, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        add_row(ROW_LOAD, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 7'd4, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h4000_0000, 0, 0);
        add_row(ROW_LOAD, 1, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 7'd2, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'd5, 0, 1);
        add_row(ROW_LOAD, 1, 32'd1, 0, 0, 0, 0, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 7'd4, 0);
        add_row(ROW_SAMPLE, 0, 0, 0, 0, 32'h0001_2345, 0, 0);
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    write_count(dir_rows[i].cnt);
                end
                default: begin
                    send_item(dir_rows[i].kind == ROW_SAMPLE, dir_rows[i].idx, dir_rows[i].x,
                              dir_rows[i].y, dir_rows[i].z, dir_rows[i].trav,
                              dir_rows[i].given, dir_rows[i].res);
                end
            endcase
        end

        // fill every slot so that later reads never hit an unwritten entry
        load_path(NPTS);
        n_items = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 19 : (ph == 1) ? 72 : 0;
            recv_idle = (ph == 0) ? 72 : (ph == 1) ? 19 : 0;
            while (n_items < (ph + 1) * 660) begin
                cnt_sel = $urandom_range(0, 8);
                write_count(cnt_sel == 8 ? 7'($urandom_range(0, 127)) : cnts[cnt_sel]);
                if (ph == 1 && !hold_req) hold_req = 1;
                n = path_cnt > NPTS ? NPTS : path_cnt;
                if ($urandom_range(0, 3) != 0) begin
                    load_path(n);
                    n_items += n;
                end
                repeat ($urandom_range(10, 30)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_item(1'b0, 6'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                                  rand_coord(), $urandom, 0, '0);
                    else
                        send_item(1'b1, 6'($urandom), $urandom, $urandom, $urandom,
                                  rand_travel(), 0, '0);
                    n_items++;
                end
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
